FILE: rtl/aesd_pkg.sv
package aesd_pkg;

  localparam int NumRounds = 10;
  localparam int KeyWidth  = 128;
  localparam int HalfWidth = 64;

  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  typedef logic [KeyWidth-1:0] block_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

  // Byte i of a block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input block_t b, input int i);
    get_byte = b[KeyWidth-1-8*i -: 8];
  endfunction

  function automatic block_t inv_shift_sub(input block_t s);
    block_t t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[KeyWidth-1-8*(r+4*c) -: 8] = inv_sbox(get_byte(s, r + 4*((c + 4 - r) % 4)));
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = get_byte(s, 4*c + k);
        x2[k] = xtime(a[k]);
        x4[k] = xtime(x2[k]);
        x8[k] = xtime(x4[k]);
        m9[k] = x8[k] ^ a[k];
        mb[k] = x8[k] ^ x2[k] ^ a[k];
        md[k] = x8[k] ^ x4[k] ^ a[k];
        me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      t[KeyWidth-1-8*(4*c)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      t[KeyWidth-1-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      t[KeyWidth-1-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      t[KeyWidth-1-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    inv_mix = t;
  endfunction

  // One step of the forward key schedule.
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    block_t n;
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    n[127:96] = w0 ^ t;
    n[95:64]  = w1 ^ w0 ^ t;
    n[63:32]  = w2 ^ w1 ^ w0 ^ t;
    n[31:0]   = w3 ^ w2 ^ w1 ^ w0 ^ t;
    next_key = n;
  endfunction

endpackage

FILE: rtl/aes128_block_decrypt.sv
// An accepted input beat passes the key-add register st[0] and then ten round cells,
// one register stage each. Throughput: one block per cycle when not stalled.
// The whole chain advances together and stalls when the output beat is not taken.
// Reset (synchronous) clears the key to zero and all valid flags.
// After reset or a key write, s_axis_tready stays low until the round keys have
// settled.
module aes128_block_decrypt (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // cipher_high, cipher_low
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // plain_high, plain_low
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import aesd_pkg::*;

  block_t rk [NumRounds+1];
  block_t st [NumRounds+1];
  logic [NumRounds:0] vld;
  logic adv;
  logic keys_ready;

  aesd_keys u_keys (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .round_key(rk), .keys_ready(keys_ready)
  );

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && keys_ready;

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ rk[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NumRounds-1:0], s_axis_tvalid && keys_ready};
    end
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    aesd_round_cell u_cell (
      .clk(clk), .en(adv), .mix(g != NumRounds-1),
      .state_in(st[g]), .round_key(rk[NumRounds-1-g]), .state_out(st[g+1])
    );
  end

  assign m_axis_tvalid = vld[NumRounds];
  assign m_axis_tdata  = {st[NumRounds][63:0], st[NumRounds][127:64]};
endmodule

FILE: rtl/aesd_keys.sv
module aesd_keys (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output aesd_pkg::block_t    round_key [aesd_pkg::NumRounds+1],
  output logic                keys_ready
);
  import aesd_pkg::*;

  block_t key;
  logic [7:0] rcon [NumRounds];
  logic [3:0] settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKeyHigh: key[127:64] <= cfg_data;
        RegKeyLow:  key[63:0]   <= cfg_data;
        default:    key <= key;
      endcase
    end
  end

  // The schedule is expanded one step per clock from the held key. After reset or
  // a key write, input is held off until every round key register has settled.
  always_ff @(posedge clk) begin
    round_key[0] <= key;
    for (int i = 1; i <= NumRounds; i++) begin
      round_key[i] <= next_key(round_key[i-1], rcon[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= 4'(NumRounds + 1);
    end else if (settle != '0) begin
      settle <= settle - 4'd1;
    end
  end

  assign keys_ready = (settle == '0);

  always_comb begin
    rcon[0] = 8'h01;
    for (int i = 1; i < NumRounds; i++) begin
      rcon[i] = xtime(rcon[i-1]);
    end
  end
endmodule

FILE: rtl/aesd_round_cell.sv
module aesd_round_cell (
  input  logic             clk,
  input  logic             en,
  input  logic             mix,
  input  aesd_pkg::block_t state_in,
  input  aesd_pkg::block_t round_key,
  output aesd_pkg::block_t state_out
);
  import aesd_pkg::*;

  block_t added;

  assign added = inv_shift_sub(state_in) ^ round_key;

  always_ff @(posedge clk) begin
    if (en) begin
      state_out <= mix ? inv_mix(added) : added;
    end
  end
endmodule
